@@ rtl/xor_trie_multiset_max_xor_top_assert.svh @@
// Assertion macros shared by the trie block's RTL files.
// Define NO_ASSERTIONS to compile them away.
`ifndef XOR_TRIE_MULTISET_MAX_XOR_TOP_ASSERT_SVH
`define XOR_TRIE_MULTISET_MAX_XOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define XT_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define XT_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define XT_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define XT_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

@@ rtl/xtmx_pkg.sv @@
// Package for the maximum-XOR trie block: item types, codes and states.
// No dependencies.
`default_nettype none
package xtmx_pkg;
  localparam int KEY_W = 19;
  localparam int XOR_W = 19;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [XOR_W-1:0] max_xor;
    logic [1:0]       status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CRD, S_CWT, S_CCHK, S_URD, S_UWT, S_UDO, S_QRD, S_QWT, S_QDO, S_DONE
  } bstate_t;
endpackage
`default_nettype wire

@@ rtl/xtmx_front.sv @@
// Front end: holds accepted items in a two-entry queue; the back end classifies the request.
// Depends on xtmx_pkg.
`default_nettype none
module xtmx_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire xtmx_pkg::in_item_t   push_item,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      avail,
  output xtmx_pkg::in_item_t        head
);
  xtmx_pkg::in_item_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign head  = q_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_item;
  end

  `include "xor_trie_multiset_max_xor_top_assert.svh"
  `XT_ASSERT_IMP(a_no_overfill, clk, rst_n, push, !full || pop, "item pushed into full queue")
  `XT_ASSERT_IMP(a_no_underrun, clk, rst_n, pop, avail, "pop from empty queue")
  `XT_ASSERT_NXT(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= 2'd2, "queue count out of range")
endmodule
`default_nettype wire

@@ rtl/xtmx_back.sv @@
// Back end: walks the trie in the node store and produces one result per item.
// Depends on xtmx_pkg.
`default_nettype none
module xtmx_back #(
  parameter int NODE_COUNT = 8192,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                avail,
  input  wire xtmx_pkg::in_item_t  head,
  output logic                     pop,
  output logic                     out_valid,
  output xtmx_pkg::out_item_t      out_item
);
  localparam int KEY_BITS = xtmx_pkg::KEY_W;
  localparam int NW = $clog2(NODE_COUNT);
  localparam int FW = NW + 1;
  localparam int BW = $clog2(KEY_BITS + 1);

  logic [NW-1:0]         lz_mem [NODE_COUNT];
  logic [NW-1:0]         lo_mem [NODE_COUNT];
  logic [COUNT_BITS-1:0] cn_mem [NODE_COUNT];

  xtmx_pkg::bstate_t state_r, state_nxt;
  logic [1:0]          req_r;
  logic [KEY_BITS-1:0] key_r;
  logic [NW-1:0]       cur_r, cur_nxt;
  logic [BW-1:0]       bit_r, bit_nxt;
  logic [FW-1:0]       free_r, free_nxt;
  logic [KEY_BITS-1:0] acc_r, acc_nxt;
  logic [1:0]          st_r, st_nxt;
  logic                fresh_r, fresh_nxt;

  // Registered reads of the node at the current address.
  logic [NW-1:0]         rz_r, ro_r;
  logic [COUNT_BITS-1:0] cz_r, co_r;
  logic [NW-1:0]         root_z_r, root_o_r;

  logic [NW-1:0]         lwa, cwa;
  logic [NW-1:0]         lz_d, lo_d;
  logic [COUNT_BITS-1:0] cw_d;
  logic                  lwe, cwe;
  logic                  root_we;
  logic [NW-1:0]         nl_a;
  logic                  rd_en, cn_en;
  logic                  in_idle, in_done;

  logic kb;
  logic [NW-1:0] nx_link, op_link;
  logic [COUNT_BITS-1:0] nx_cnt, op_cnt;

  assign kb      = key_r[bit_r - BW'(1)];
  assign nx_link = kb ? ro_r : rz_r;
  assign nx_cnt  = kb ? co_r : cz_r;
  assign op_link = kb ? rz_r : ro_r;
  assign op_cnt  = kb ? cz_r : co_r;
  assign nl_a    = free_r[NW-1:0];

  assign in_idle = (state_r == xtmx_pkg::S_IDLE);
  assign in_done = (state_r == xtmx_pkg::S_DONE);
  assign rd_en   = (state_r == xtmx_pkg::S_CRD) || (state_r == xtmx_pkg::S_URD) ||
                   (state_r == xtmx_pkg::S_QRD);
  assign cn_en   = (state_r == xtmx_pkg::S_CWT) || (state_r == xtmx_pkg::S_UWT) ||
                   (state_r == xtmx_pkg::S_QWT);

  // Child counts are read in the cycle after the links that address them.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rz_r <= (cur_r == '0) ? root_z_r : lz_mem[cur_r];
      ro_r <= (cur_r == '0) ? root_o_r : lo_mem[cur_r];
    end
    if (cn_en) begin
      cz_r <= cn_mem[rz_r];
      co_r <= cn_mem[ro_r];
    end
  end

  always_ff @(posedge clk) begin
    if (lwe) begin
      lz_mem[lwa] <= lz_d;
      lo_mem[lwa] <= lo_d;
    end
    if (cwe) cn_mem[cwa] <= cw_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_z_r <= '0;
      root_o_r <= '0;
    end else if (root_we) begin
      if (kb) root_o_r <= nl_a;
      else root_z_r <= nl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xtmx_pkg::S_IDLE;
      free_r  <= FW'(1);
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
    end
    if (in_idle && avail) begin
      req_r <= head.req_type;
      key_r <= head.key_value;
    end
    cur_r   <= cur_nxt;
    bit_r   <= bit_nxt;
    acc_r   <= acc_nxt;
    st_r    <= st_nxt;
    fresh_r <= fresh_nxt;
  end

  // Once a node is missing, every deeper node on the path is freshly allocated
  // and its links are known without reading them.
  always_comb begin
    state_nxt = state_r;
    cur_nxt = cur_r;
    bit_nxt = bit_r;
    free_nxt = free_r;
    acc_nxt = acc_r;
    st_nxt = st_r;
    fresh_nxt = fresh_r;
    pop = 1'b0;
    out_valid = 1'b0;
    out_item.max_xor = xtmx_pkg::XOR_W'(acc_r);
    out_item.status = st_r;
    lwe = 1'b0; lwa = '0; lz_d = '0; lo_d = '0;
    cwe = 1'b0; cwa = '0; cw_d = '0;
    root_we = 1'b0;
    unique case (state_r)
      xtmx_pkg::S_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          cur_nxt = '0;
          bit_nxt = BW'(KEY_BITS);
          acc_nxt = '0;
          fresh_nxt = 1'b0;
          st_nxt = xtmx_pkg::ST_OK;
          unique case (head.req_type)
            xtmx_pkg::REQ_INSERT, xtmx_pkg::REQ_REMOVE: state_nxt = xtmx_pkg::S_CRD;
            xtmx_pkg::REQ_QUERY: state_nxt = xtmx_pkg::S_QRD;
            default: state_nxt = xtmx_pkg::S_DONE;
          endcase
        end
      end
      xtmx_pkg::S_CRD: state_nxt = xtmx_pkg::S_CWT;
      xtmx_pkg::S_CWT: state_nxt = xtmx_pkg::S_CCHK;
      xtmx_pkg::S_CCHK: begin
        if (req_r == xtmx_pkg::REQ_INSERT) begin
          if (nx_link == '0) begin
            cur_nxt = '0; bit_nxt = BW'(KEY_BITS);
            if ({1'b0, free_r} + {1'b0, FW'(bit_r)} > (FW+1)'(NODE_COUNT)) begin
              st_nxt = xtmx_pkg::ST_FULL;
              state_nxt = xtmx_pkg::S_DONE;
            end else begin
              state_nxt = xtmx_pkg::S_URD;
            end
          end else if (&nx_cnt) begin
            st_nxt = xtmx_pkg::ST_FULL;
            state_nxt = xtmx_pkg::S_DONE;
          end else if (bit_r == BW'(1)) begin
            cur_nxt = '0; bit_nxt = BW'(KEY_BITS);
            state_nxt = xtmx_pkg::S_URD;
          end else begin
            cur_nxt = nx_link; bit_nxt = bit_r - BW'(1);
            state_nxt = xtmx_pkg::S_CRD;
          end
        end else begin
          if (nx_link == '0 || nx_cnt == '0) begin
            st_nxt = xtmx_pkg::ST_NOT_FOUND;
            state_nxt = xtmx_pkg::S_DONE;
          end else if (bit_r == BW'(1)) begin
            cur_nxt = '0; bit_nxt = BW'(KEY_BITS);
            state_nxt = xtmx_pkg::S_URD;
          end else begin
            cur_nxt = nx_link; bit_nxt = bit_r - BW'(1);
            state_nxt = xtmx_pkg::S_CRD;
          end
        end
      end
      xtmx_pkg::S_URD: state_nxt = xtmx_pkg::S_UWT;
      xtmx_pkg::S_UWT: state_nxt = xtmx_pkg::S_UDO;
      xtmx_pkg::S_UDO: begin
        if (req_r == xtmx_pkg::REQ_INSERT && (fresh_r || nx_link == '0)) begin
          cwe = 1'b1; cwa = nl_a; cw_d = COUNT_BITS'(1);
          free_nxt = free_r + FW'(1);
          fresh_nxt = 1'b1;
          if (cur_r == '0) begin
            root_we = 1'b1;
          end else begin
            lwe = 1'b1;
            lwa = cur_r;
            if (fresh_r) begin
              lz_d = kb ? '0 : nl_a;
              lo_d = kb ? nl_a : '0;
            end else begin
              lz_d = kb ? rz_r : nl_a;
              lo_d = kb ? nl_a : ro_r;
            end
          end
          cur_nxt = nl_a;
          if (bit_r == BW'(1)) state_nxt = xtmx_pkg::S_DONE;
          else begin
            bit_nxt = bit_r - BW'(1);
            state_nxt = xtmx_pkg::S_UDO;
          end
        end else begin
          cwe = 1'b1; cwa = nx_link;
          cw_d = (req_r == xtmx_pkg::REQ_INSERT) ? nx_cnt + COUNT_BITS'(1) :
                                                   nx_cnt - COUNT_BITS'(1);
          cur_nxt = nx_link;
          if (bit_r == BW'(1)) state_nxt = xtmx_pkg::S_DONE;
          else begin
            bit_nxt = bit_r - BW'(1);
            state_nxt = xtmx_pkg::S_URD;
          end
        end
      end
      xtmx_pkg::S_QRD: state_nxt = xtmx_pkg::S_QWT;
      xtmx_pkg::S_QWT: state_nxt = xtmx_pkg::S_QDO;
      xtmx_pkg::S_QDO: begin
        if (bit_r == BW'(KEY_BITS) &&
            !((rz_r != '0 && cz_r != '0) || (ro_r != '0 && co_r != '0))) begin
          st_nxt = xtmx_pkg::ST_EMPTY;
          state_nxt = xtmx_pkg::S_DONE;
        end else if (op_link != '0 && op_cnt != '0) begin
          acc_nxt = acc_r | (KEY_BITS'(1) << (bit_r - BW'(1)));
          cur_nxt = op_link;
          state_nxt = (bit_r == BW'(1)) ? xtmx_pkg::S_DONE : xtmx_pkg::S_QRD;
          bit_nxt = bit_r - BW'(1);
        end else if (nx_link == '0) begin
          state_nxt = xtmx_pkg::S_DONE;
        end else begin
          cur_nxt = nx_link;
          state_nxt = (bit_r == BW'(1)) ? xtmx_pkg::S_DONE : xtmx_pkg::S_QRD;
          bit_nxt = bit_r - BW'(1);
        end
      end
      xtmx_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (st_r != xtmx_pkg::ST_OK) out_item.max_xor = '0;
        // A freshly allocated leaf gets its null links here.
        if (fresh_r) begin
          lwe = 1'b1;
          lwa = cur_r;
        end
        state_nxt = xtmx_pkg::S_IDLE;
      end
      default: state_nxt = xtmx_pkg::S_IDLE;
    endcase
  end

  `include "xor_trie_multiset_max_xor_top_assert.svh"
  `XT_ASSERT_NXT(a_done_to_idle, clk, rst_n, in_done, in_idle, "result state not left")
  `XT_ASSERT_IMP(a_pop_idle, clk, rst_n, pop, in_idle, "pop while busy")
  `XT_ASSERT_IMP(a_free_bound, clk, rst_n, 1'b1, free_r <= FW'(NODE_COUNT), "pool overrun")
endmodule
`default_nettype wire

@@ rtl/xor_trie_multiset_max_xor_top.sv @@
// Maximum-XOR multiset of 19-bit keys. Items are taken while busy is low into a
// two-entry queue, and busy rises only while that queue is full. Items are carried
// out one after another, each pass walking the key bits through dependent node-store
// reads: a query makes one pass, an insert or remove a check pass and an update
// pass, where each newly allocated level after the first needs no read. Results come
// with out_valid for one cycle and cannot be stalled. Depends on xtmx_pkg,
// xtmx_front, xtmx_back.
`default_nettype none
module xor_trie_multiset_max_xor_top #(
  parameter int NODE_COUNT = 8192,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire xtmx_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output xtmx_pkg::out_item_t      out_item
);
  logic full, avail, pop;
  xtmx_pkg::in_item_t head;

  assign busy = full;

  xtmx_front u_front (
    .clk(clk), .rst_n(rst_n), .push(start && !full), .push_item(in_item),
    .full(full), .pop(pop), .avail(avail), .head(head)
  );

  xtmx_back #(.NODE_COUNT(NODE_COUNT), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .avail(avail), .head(head), .pop(pop),
    .out_valid(out_valid), .out_item(out_item)
  );
endmodule
`default_nettype wire

@@ tb/sv/tb_xor_trie_multiset_max_xor_top.sv @@
// Testbench for the maximum-XOR trie multiset: directed and random requests,
// with results checked against a trie predictor held in a scoreboard class.
// Depends on xtmx_pkg and xor_trie_multiset_max_xor_top.
`default_nettype none
module tb_xor_trie_multiset_max_xor_top;
  localparam int NODES = 8192;
  localparam int KBITS = 19;
  localparam int STALL_LIMIT = 5000;

  class trie_scoreboard;
    logic [12:0] zero_link[NODES];
    logic [12:0] one_link[NODES];
    logic [15:0] node_uses[NODES];
    int next_node;
    xtmx_pkg::out_item_t pending[$];
    int mismatches;
    int full_count;

    function new();
      for (int i = 0; i < NODES; i++) begin
        zero_link[i] = '0;
        one_link[i] = '0;
        node_uses[i] = '0;
      end
      next_node = 1;
      mismatches = 0;
      full_count = 0;
    endfunction

    function logic [12:0] child(int node, logic bit_sel);
      return bit_sel ? one_link[node] : zero_link[node];
    endfunction

    function bit alive(logic [12:0] node);
      return node != 0 && node_uses[node] != 0;
    endfunction

    function xtmx_pkg::status_t insert_key(logic [KBITS-1:0] key);
      int cur;
      int missing;
      logic [12:0] nx;
      cur = 0;
      missing = 0;
      for (int b = KBITS - 1; b >= 0; b--) begin
        nx = child(cur, key[b]);
        if (nx == 0) begin
          missing = b + 1;
          break;
        end
        if (node_uses[nx] == 16'hFFFF) return xtmx_pkg::ST_FULL;
        cur = nx;
      end
      if (next_node + missing > NODES) return xtmx_pkg::ST_FULL;
      cur = 0;
      for (int b = KBITS - 1; b >= 0; b--) begin
        nx = child(cur, key[b]);
        if (nx == 0) begin
          nx = next_node[12:0];
          next_node++;
          zero_link[nx] = '0;
          one_link[nx] = '0;
          node_uses[nx] = '0;
          if (key[b]) one_link[cur] = nx;
          else zero_link[cur] = nx;
        end
        node_uses[nx] = node_uses[nx] + 16'd1;
        cur = nx;
      end
      return xtmx_pkg::ST_OK;
    endfunction

    function xtmx_pkg::status_t remove_key(logic [KBITS-1:0] key);
      int cur;
      logic [12:0] nx;
      cur = 0;
      for (int b = KBITS - 1; b >= 0; b--) begin
        nx = child(cur, key[b]);
        if (!alive(nx)) return xtmx_pkg::ST_NOT_FOUND;
        cur = nx;
      end
      cur = 0;
      for (int b = KBITS - 1; b >= 0; b--) begin
        nx = child(cur, key[b]);
        node_uses[nx] = node_uses[nx] - 16'd1;
        cur = nx;
      end
      return xtmx_pkg::ST_OK;
    endfunction

    function xtmx_pkg::status_t best_xor(logic [KBITS-1:0] key,
                                         output logic [KBITS-1:0] acc);
      int cur;
      logic [12:0] want;
      logic [12:0] same;
      acc = '0;
      if (!alive(zero_link[0]) && !alive(one_link[0])) return xtmx_pkg::ST_EMPTY;
      cur = 0;
      for (int b = KBITS - 1; b >= 0; b--) begin
        want = child(cur, ~key[b]);
        if (alive(want)) begin
          acc[b] = 1'b1;
          cur = want;
        end else begin
          same = child(cur, key[b]);
          if (same == 0) break;
          cur = same;
        end
      end
      return xtmx_pkg::ST_OK;
    endfunction

    function void note_request(xtmx_pkg::in_item_t req);
      xtmx_pkg::out_item_t res;
      logic [KBITS-1:0] acc;
      xtmx_pkg::status_t st;
      acc = '0;
      st = xtmx_pkg::ST_OK;
      case (xtmx_pkg::req_t'(req.req_type))
        xtmx_pkg::REQ_INSERT: st = insert_key(req.key_value);
        xtmx_pkg::REQ_REMOVE: st = remove_key(req.key_value);
        xtmx_pkg::REQ_QUERY: st = best_xor(req.key_value, acc);
        default: st = xtmx_pkg::ST_OK;
      endcase
      if (st == xtmx_pkg::ST_FULL) full_count++;
      res.max_xor = acc;
      res.status = st;
      pending = {pending, res};
    endfunction

    function void check_result(xtmx_pkg::out_item_t got);
      xtmx_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: max_xor=%h status=%0d", got.max_xor, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.max_xor !== want.max_xor || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected max_xor=%h status=%0d, got max_xor=%h status=%0d",
                   want.max_xor, want.status, got.max_xor, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  xtmx_pkg::in_item_t in_item = '0;
  logic out_valid;
  xtmx_pkg::out_item_t out_item;

  trie_scoreboard sb = new();
  int idle_pct = 0;
  int quiet_cycles = 0;
  logic [KBITS-1:0] key_pool[24];

  xor_trie_multiset_max_xor_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_item);
      if (out_valid) sb.check_result(out_item);
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(xtmx_pkg::req_t op, logic [KBITS-1:0] key);
    xtmx_pkg::in_item_t item;
    item.req_type = op;
    item.key_value = key;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [KBITS-1:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(23)];
    return KBITS'($urandom_range(2**KBITS - 1));
  endfunction

  task automatic random_phase(int count);
    int r;
    xtmx_pkg::req_t op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 40) op = xtmx_pkg::REQ_INSERT;
      else if (r < 68) op = xtmx_pkg::REQ_REMOVE;
      else if (r < 95) op = xtmx_pkg::REQ_QUERY;
      else op = xtmx_pkg::REQ_NONE;
      if ($urandom_range(99) < 3)
        key_pool[$urandom_range(23)] = KBITS'($urandom_range(2**KBITS - 1));
      send_item(op, pick_key());
    end
  endtask

  initial begin
    int fill;
    for (int i = 0; i < 24; i++) key_pool[i] = KBITS'($urandom_range(2**KBITS - 1));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(xtmx_pkg::REQ_QUERY, 19'h00000);
    send_item(xtmx_pkg::REQ_REMOVE, 19'h12345);
    send_item(xtmx_pkg::REQ_INSERT, 19'h00000);
    send_item(xtmx_pkg::REQ_QUERY, 19'h00000);
    send_item(xtmx_pkg::REQ_QUERY, 19'h7FFFF);
    send_item(xtmx_pkg::REQ_INSERT, 19'h7FFFF);
    send_item(xtmx_pkg::REQ_QUERY, 19'h00000);
    send_item(xtmx_pkg::REQ_QUERY, 19'h2AAAA);
    send_item(xtmx_pkg::REQ_INSERT, 19'h7FFFF);
    send_item(xtmx_pkg::REQ_REMOVE, 19'h7FFFF);
    send_item(xtmx_pkg::REQ_REMOVE, 19'h7FFFF);
    send_item(xtmx_pkg::REQ_REMOVE, 19'h7FFFF);
    send_item(xtmx_pkg::REQ_QUERY, 19'h7FFFF);
    send_item(xtmx_pkg::REQ_NONE, 19'h55555);
    send_item(xtmx_pkg::REQ_REMOVE, 19'h00001);
    send_item(xtmx_pkg::REQ_REMOVE, 19'h00000);
    send_item(xtmx_pkg::REQ_QUERY, 19'h55555);
    send_item(xtmx_pkg::REQ_INSERT, 19'h55555);
    send_item(xtmx_pkg::REQ_INSERT, 19'h2AAAA);
    send_item(xtmx_pkg::REQ_QUERY, 19'h55555);

    idle_pct = 0;
    random_phase(80);
    idle_pct = 73;
    random_phase(80);
    idle_pct = 0;
    random_phase(80);
    idle_pct = 10;
    random_phase(80);

    // Fresh random keys fill the node pool until four inserts are refused, or 3000 are sent.
    idle_pct = 0;
    fill = 0;
    while (sb.full_count < 4 && fill < 3000) begin
      send_item(xtmx_pkg::REQ_INSERT, KBITS'($urandom_range(2**KBITS - 1)));
      fill++;
    end
    idle_pct = 10;
    random_phase(60);
    release_start();

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
